FILE: src/qtrs_pkg.sv
// ----------------------------------------------------------------------------
// qtrs_pkg
// Shared types and constants for the quaternion TRS model matrix pipeline.
// ----------------------------------------------------------------------------
package qtrs_pkg;

  // Field widths
  localparam int QUAT_W = 16;               // Q2.14 component
  localparam int FIX_W  = 32;               // Q16.16 value
  localparam int PROD_W = 2 * QUAT_W;       // exact component product
  localparam int TERM_W = PROD_W + 2;       // doubled sum of products, Q6.28
  localparam int LO_W   = TERM_W / 2;       // low slice of a term (unsigned)
  localparam int HI_W   = TERM_W - LO_W;    // high slice of a term (signed)
  localparam int PPH_W  = HI_W + FIX_W;     // high partial product
  localparam int PPL_W  = LO_W + 1 + FIX_W; // low partial product
  localparam int SUM_W  = PPH_W + LO_W;     // full term * scale, Q.44
  localparam int FRAC_SHIFT = 28;           // Q.44 -> Q16.16
  localparam int RND_W  = SUM_W - FRAC_SHIFT;

  // Row codes
  localparam logic [1:0] ROW_X   = 2'd0;
  localparam logic [1:0] ROW_Y   = 2'd1;
  localparam logic [1:0] ROW_Z   = 2'd2;
  localparam logic [1:0] ROW_POS = 2'd3;

  // Fixed-point constants
  localparam logic signed [FIX_W-1:0] FIX_ONE  = 32'sh0001_0000;
  localparam logic signed [FIX_W-1:0] FIX_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [FIX_W-1:0] FIX_MIN  = 32'sh8000_0000;
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (FRAC_SHIFT - 1);

  // Per-row control and pass-through data that follows each beat
  typedef struct packed {
    logic [1:0]              row;
    logic signed [FIX_W-1:0] scl;
    logic signed [FIX_W-1:0] px;
    logic signed [FIX_W-1:0] py;
    logic signed [FIX_W-1:0] pz;
  } row_ctl_t;

  // All ten quaternion component products
  typedef struct packed {
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] zz;
    logic signed [PROD_W-1:0] ww;
    logic signed [PROD_W-1:0] xy;
    logic signed [PROD_W-1:0] xz;
    logic signed [PROD_W-1:0] yz;
    logic signed [PROD_W-1:0] xw;
    logic signed [PROD_W-1:0] yw;
    logic signed [PROD_W-1:0] zw;
  } quat_prod_t;

  // Three rotation terms of one row
  typedef struct packed {
    logic signed [TERM_W-1:0] t0;
    logic signed [TERM_W-1:0] t1;
    logic signed [TERM_W-1:0] t2;
  } row_terms_t;

endpackage

FILE: src/qtrs_issue.sv
// ----------------------------------------------------------------------------
// qtrs_issue
// Holds one transform and issues its four rows, one per advancing cycle,
// together with the registered quaternion products.
// ----------------------------------------------------------------------------
module qtrs_issue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              quat_x,
  input  logic signed [15:0]              quat_y,
  input  logic signed [15:0]              quat_z,
  input  logic signed [15:0]              quat_w,
  input  logic signed [31:0]              pos_x,
  input  logic signed [31:0]              pos_y,
  input  logic signed [31:0]              pos_z,
  input  logic signed [31:0]              scale_x,
  input  logic signed [31:0]              scale_y,
  input  logic signed [31:0]              scale_z,
  output logic                            s1_valid,
  output qtrs_pkg::row_ctl_t              s1_ctl,
  output qtrs_pkg::quat_prod_t            s1_prod
);
  import qtrs_pkg::*;

  // Held transform
  logic                      hold_valid;
  logic [1:0]                row_cnt;
  logic signed [QUAT_W-1:0]  hx, hy, hz, hw;
  logic signed [FIX_W-1:0]   hpx, hpy, hpz, hsx, hsy, hsz;

  logic       issue;
  logic       last_issue;
  logic       accept;
  row_ctl_t   ctl_next;
  quat_prod_t prod_next;

  assign issue      = en && hold_valid;
  assign last_issue = issue && (row_cnt == ROW_POS);
  assign in_stall   = hold_valid && !last_issue;
  assign accept     = in_valid && !in_stall;

  // Row control and products for the row being issued
  always_comb begin
    ctl_next.row = row_cnt;
    ctl_next.px  = hpx;
    ctl_next.py  = hpy;
    ctl_next.pz  = hpz;
    case (row_cnt)
      ROW_X:   ctl_next.scl = hsx;
      ROW_Y:   ctl_next.scl = hsy;
      ROW_Z:   ctl_next.scl = hsz;
      default: ctl_next.scl = '0;
    endcase
    prod_next.xx = hx * hx;
    prod_next.yy = hy * hy;
    prod_next.zz = hz * hz;
    prod_next.ww = hw * hw;
    prod_next.xy = hx * hy;
    prod_next.xz = hx * hz;
    prod_next.yz = hy * hz;
    prod_next.xw = hx * hw;
    prod_next.yw = hy * hw;
    prod_next.zw = hz * hw;
  end

  // Hold register and row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      row_cnt    <= ROW_X;
      s1_valid   <= 1'b0;
    end else begin
      if (en) begin
        s1_valid <= hold_valid;
      end
      if (accept) begin
        hold_valid <= 1'b1;
        row_cnt    <= ROW_X;
      end else if (last_issue) begin
        hold_valid <= 1'b0;
      end else if (issue) begin
        row_cnt <= row_cnt + 2'd1;
      end
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      hx  <= quat_x;
      hy  <= quat_y;
      hz  <= quat_z;
      hw  <= quat_w;
      hpx <= pos_x;
      hpy <= pos_y;
      hpz <= pos_z;
      hsx <= scale_x;
      hsy <= scale_y;
      hsz <= scale_z;
    end
    if (en) begin
      s1_ctl  <= ctl_next;
      s1_prod <= prod_next;
    end
  end

endmodule

FILE: src/qtrs_terms.sv
// ----------------------------------------------------------------------------
// qtrs_terms
// Forms the three rotation terms of a row (Q6.28) from the products.
// ----------------------------------------------------------------------------
module qtrs_terms (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 s1_valid,
  input  qtrs_pkg::row_ctl_t   s1_ctl,
  input  qtrs_pkg::quat_prod_t s1_prod,
  output logic                 s2_valid,
  output qtrs_pkg::row_ctl_t   s2_ctl,
  output qtrs_pkg::row_terms_t s2_terms
);
  import qtrs_pkg::*;

  logic signed [TERM_W-1:0] xx, yy, zz, ww, xy, xz, yz, xw, yw, zw;
  row_terms_t               terms_next;

  function automatic logic signed [TERM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
    ext = {{(TERM_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  // Sign-extend products to term width
  always_comb begin
    xx = ext(s1_prod.xx);
    yy = ext(s1_prod.yy);
    zz = ext(s1_prod.zz);
    ww = ext(s1_prod.ww);
    xy = ext(s1_prod.xy);
    xz = ext(s1_prod.xz);
    yz = ext(s1_prod.yz);
    xw = ext(s1_prod.xw);
    yw = ext(s1_prod.yw);
    zw = ext(s1_prod.zw);
  end

  // Row terms: diagonal is a signed sum of squares, off-diagonal doubled
  always_comb begin
    case (s1_ctl.row)
      ROW_X: begin
        terms_next.t0 = xx - yy - zz + ww;
        terms_next.t1 = (xy - zw) <<< 1;
        terms_next.t2 = (xz + yw) <<< 1;
      end
      ROW_Y: begin
        terms_next.t0 = (xy + zw) <<< 1;
        terms_next.t1 = yy - xx - zz + ww;
        terms_next.t2 = (yz - xw) <<< 1;
      end
      ROW_Z: begin
        terms_next.t0 = (xz - yw) <<< 1;
        terms_next.t1 = (yz + xw) <<< 1;
        terms_next.t2 = zz - xx - yy + ww;
      end
      default: begin
        terms_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctl   <= s1_ctl;
      s2_terms <= terms_next;
    end
  end

endmodule

FILE: src/qtrs_scale.sv
// ----------------------------------------------------------------------------
// qtrs_scale
// Multiplies each term by the row scale in two partial products, rounds
// half up to Q16.16, saturates, and drives the output row register.
// ----------------------------------------------------------------------------
module qtrs_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 s2_valid,
  input  qtrs_pkg::row_ctl_t   s2_ctl,
  input  qtrs_pkg::row_terms_t s2_terms,
  output logic                 out_valid,
  output logic [1:0]           row_index,
  output logic signed [31:0]   col0,
  output logic signed [31:0]   col1,
  output logic signed [31:0]   col2,
  output logic signed [31:0]   col3,
  output logic                 last_row
);
  import qtrs_pkg::*;

  localparam int NT = 3;

  logic signed [TERM_W-1:0] term [NT];
  logic signed [PPH_W-1:0]  pph_next [NT];
  logic signed [PPL_W-1:0]  ppl_next [NT];
  logic signed [HI_W-1:0]   hi_s [NT];
  logic signed [LO_W:0]     lo_s [NT];

  // Stage 3 registers: partial products
  logic                     s3_valid;
  row_ctl_t                 s3_ctl;
  logic signed [PPH_W-1:0]  pph [NT];
  logic signed [PPL_W-1:0]  ppl [NT];

  // Stage 4 registers: rounded values before saturation
  logic                     s4_valid;
  row_ctl_t                 s4_ctl;
  logic signed [SUM_W-1:0]  sum_next [NT];
  logic signed [RND_W-1:0]  rnd_next [NT];
  logic signed [RND_W-1:0]  rnd [NT];

  logic signed [FIX_W-1:0]  sat [NT];

  assign term[0] = s2_terms.t0;
  assign term[1] = s2_terms.t1;
  assign term[2] = s2_terms.t2;

  // Split term: signed high slice and unsigned low slice, each times scale
  always_comb begin
    for (int i = 0; i < NT; i++) begin
      hi_s[i]     = term[i][TERM_W-1:LO_W];
      lo_s[i]     = {1'b0, term[i][LO_W-1:0]};
      pph_next[i] = hi_s[i] * s2_ctl.scl;
      ppl_next[i] = lo_s[i] * s2_ctl.scl;
    end
  end

  // Recombine, add half LSB, floor to Q16.16
  always_comb begin
    for (int i = 0; i < NT; i++) begin
      sum_next[i] = {pph[i], {LO_W{1'b0}}}
                  + {{(SUM_W-PPL_W){ppl[i][PPL_W-1]}}, ppl[i]}
                  + RND_HALF;
      rnd_next[i] = sum_next[i][SUM_W-1:FRAC_SHIFT];
    end
  end

  // Saturate to signed 32 bits
  always_comb begin
    for (int i = 0; i < NT; i++) begin
      if (rnd[i][RND_W-1:FIX_W-1] == {(RND_W-FIX_W+1){rnd[i][RND_W-1]}}) begin
        sat[i] = rnd[i][FIX_W-1:0];
      end else if (rnd[i][RND_W-1]) begin
        sat[i] = FIX_MIN;
      end else begin
        sat[i] = FIX_MAX;
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      s3_ctl <= s2_ctl;
      s4_ctl <= s3_ctl;
      for (int i = 0; i < NT; i++) begin
        pph[i] <= pph_next[i];
        ppl[i] <= ppl_next[i];
        rnd[i] <= rnd_next[i];
      end
      row_index <= s4_ctl.row;
      last_row  <= (s4_ctl.row == ROW_POS);
      if (s4_ctl.row == ROW_POS) begin
        col0 <= s4_ctl.px;
        col1 <= s4_ctl.py;
        col2 <= s4_ctl.pz;
        col3 <= FIX_ONE;
      end else begin
        col0 <= sat[0];
        col1 <= sat[1];
        col2 <= sat[2];
        col3 <= '0;
      end
    end
  end

endmodule

FILE: src/quaternion_trs_model_matrix.sv
// ----------------------------------------------------------------------------
// quaternion_trs_model_matrix
// Builds a 4x4 Q16.16 model matrix from a Q2.14 quaternion, a position and
// a per-axis scale, and sends it out as four row beats.
// ----------------------------------------------------------------------------
// Each transform gives four row beats and the single output row port carries
// one row per cycle while not stalled, so a new input beat is accepted in the
// cycle the previous transform's last row is issued.
// Each row passes through the hold, products, terms, partial products, round
// and saturate registers. Rows come in order 0, 1, 2, 3 with last_row on row 3.
// Output stall freezes the pipeline past the hold register, which can still
// take a transform while empty; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quaternion_trs_model_matrix (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [31:0] scale_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         row_index,
  output logic signed [31:0] col0,
  output logic signed [31:0] col1,
  output logic signed [31:0] col2,
  output logic signed [31:0] col3,
  output logic               last_row
);
  import qtrs_pkg::*;

  logic       en;
  logic       s1_valid;
  row_ctl_t   s1_ctl;
  quat_prod_t s1_prod;
  logic       s2_valid;
  row_ctl_t   s2_ctl;
  row_terms_t s2_terms;

  // Pipeline advances unless a finished row is held by the sink
  assign en = !out_valid || !out_stall;

  qtrs_issue u_issue (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .quat_x   (quat_x),
    .quat_y   (quat_y),
    .quat_z   (quat_z),
    .quat_w   (quat_w),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .scale_x  (scale_x),
    .scale_y  (scale_y),
    .scale_z  (scale_z),
    .s1_valid (s1_valid),
    .s1_ctl   (s1_ctl),
    .s1_prod  (s1_prod)
  );

  qtrs_terms u_terms (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .s1_valid (s1_valid),
    .s1_ctl   (s1_ctl),
    .s1_prod  (s1_prod),
    .s2_valid (s2_valid),
    .s2_ctl   (s2_ctl),
    .s2_terms (s2_terms)
  );

  qtrs_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .s2_valid  (s2_valid),
    .s2_ctl    (s2_ctl),
    .s2_terms  (s2_terms),
    .out_valid (out_valid),
    .row_index (row_index),
    .col0      (col0),
    .col1      (col1),
    .col2      (col2),
    .col3      (col3),
    .last_row  (last_row)
  );

endmodule

FILE: src/qtrs_checker.sv
// ----------------------------------------------------------------------------
// qtrs_checker
// Port-level checks on row sequencing and framing, bound to the top level.
// ----------------------------------------------------------------------------
module qtrs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         row_index,
  input logic signed [31:0] col0,
  input logic signed [31:0] col3,
  input logic               last_row
);
  import qtrs_pkg::*;

  // last_row flags exactly the position row
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_row == (row_index == ROW_POS)))
    else $error("last_row does not match row_index");

  // Fourth column is 1.0 on the position row, zero elsewhere
  a_col3: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (col3 == (last_row ? FIX_ONE : 32'sd0)))
    else $error("col3 has wrong value");

  // Rows of one matrix follow each other without gaps
  a_row_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_row |=>
      out_valid && (row_index == 2'($past(row_index) + 2'd1)))
    else $error("row sequence broken");

  // After a transform is taken, the next one waits for its rows
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before rows issued");

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(row_index) && $stable(col0))
    else $error("stalled output beat changed");

endmodule

bind quaternion_trs_model_matrix qtrs_checker u_qtrs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .row_index (row_index),
  .col0      (col0),
  .col3      (col3),
  .last_row  (last_row)
);
